[rtl/core/sfrt_pkg.sv]
`default_nettype none

package sfrt_pkg;

    localparam int EXP_W = 9;

    localparam logic [7:0]  START_MARK  = 8'h53;
    localparam logic [7:0]  END_MARK    = 8'h45;
    localparam logic [15:0] TIMEOUT_RST = 16'd100;

    localparam logic [1:0] REQ_BYTE   = 2'd0;
    localparam logic [1:0] REQ_POLL   = 2'd1;
    localparam logic [1:0] REQ_RESYNC = 2'd2;

    localparam logic [2:0] EV_FRAME     = 3'd0;
    localparam logic [2:0] EV_BAD_END   = 3'd1;
    localparam logic [2:0] EV_TIMEOUT   = 3'd2;
    localparam logic [2:0] EV_REFUSED   = 3'd3;
    localparam logic [2:0] EV_OVERFLOW  = 3'd4;
    localparam logic [2:0] EV_RECOVERED = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  data_byte;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [7:0] frame_byte;
        logic       last_of_frame;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RECOV,
        ST_REFUSE,
        ST_BYTE,
        ST_OVF,
        ST_BADEND,
        ST_FRAME_RD,
        ST_FRAME_WR,
        ST_CHECK,
        ST_TMO
    } t_state;

endpackage

`default_nettype wire

[rtl/core/serial_frame_receiver_with_timeout_unit.sv]
`default_nettype none

// Length-prefixed serial frame receiver with an inactivity timeout. Each input
// transaction is a received byte, a time poll or a resync, stamped with now_ms;
// result transactions are frame bytes (last one flagged) or single events. One
// transaction is worked at a time; an unknown request code is ignored. Each
// single event is sent from a state of its own, and a complete frame is read
// from the frame store, which has one read port with registered data, so each
// byte is first read, then sent. A stalled output holds the sequencer.
module serial_frame_receiver_with_timeout_unit #(
    parameter int MAX_FRAME = 64,
    parameter int MIN_FRAME = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  sfrt_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output sfrt_pkg::t_out_item o_out_data,
    input  wire                 i_cfg_we,
    input  wire [15:0]          i_cfg_wdata
);
    import sfrt_pkg::*;

    localparam int ADDR_W = $clog2(MAX_FRAME);
    localparam int WI_W   = $clog2(MAX_FRAME + 1);

    logic [7:0] mem [MAX_FRAME];

    t_state            r_state, n_state;
    t_in_item          r_item;
    logic [15:0]       r_timeout_ms;
    logic [WI_W-1:0]   r_wi, n_wi;
    logic [EXP_W-1:0]  r_exp, n_exp;
    logic [31:0]       r_deadline, n_deadline;
    logic              r_armed, n_armed;
    logic              r_in_timeout, n_in_timeout;
    logic [WI_W-1:0]   r_flen, n_flen;
    logic [ADDR_W-1:0] r_rd_idx, n_rd_idx;
    logic [7:0]        r_rd_data;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              in_acc;
    logic              slot_free;
    logic              dl_passed;
    logic              timeout_hit;
    logic              wi_full;
    logic              keep;
    logic              complete;
    logic              good_end;
    logic              rd_last;
    logic [WI_W-1:0]   wi_inc;
    logic [EXP_W-1:0]  exp_new;
    logic [31:0]       dl_sum;
    logic              push;
    t_out_item         push_data;
    logic              mem_we;
    logic              mem_re;

    assign in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall  = (r_state != ST_IDLE);
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        dl_passed   = r_deadline < r_item.now_ms;
        timeout_hit = r_armed && dl_passed;
        dl_sum      = r_item.now_ms + 32'(r_timeout_ms);
        wi_full     = (r_wi == WI_W'(MAX_FRAME));
        wi_inc      = r_wi + WI_W'(1);
        if (r_wi == WI_W'(0)) begin
            exp_new = EXP_W'(MIN_FRAME);
        end else if (r_wi == WI_W'(1)) begin
            exp_new = EXP_W'(r_item.data_byte) + EXP_W'(2);
        end else begin
            exp_new = r_exp;
        end
        keep     = (r_wi != WI_W'(0)) || (r_item.data_byte == START_MARK);
        complete = keep && (EXP_W'(wi_inc) == exp_new);
        good_end = (r_item.data_byte == END_MARK);
        rd_last  = ((WI_W'(r_rd_idx) + WI_W'(1)) == r_flen);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                unique case (r_item.req_type)
                    REQ_BYTE: begin
                        if (r_in_timeout) n_state = dl_passed ? ST_RECOV : ST_REFUSE;
                        else              n_state = ST_BYTE;
                    end
                    REQ_POLL: begin
                        if (r_in_timeout) n_state = dl_passed ? ST_RECOV : ST_IDLE;
                        else              n_state = ST_CHECK;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_RECOV: begin
                if (slot_free) n_state = (r_item.req_type == REQ_BYTE) ? ST_BYTE : ST_IDLE;
            end
            ST_REFUSE: begin
                if (slot_free) n_state = ST_IDLE;
            end
            ST_BYTE: begin
                priority if (wi_full)  n_state = ST_OVF;
                else if (!keep)        n_state = ST_CHECK;
                else if (complete)     n_state = good_end ? ST_FRAME_RD : ST_BADEND;
                else                   n_state = ST_CHECK;
            end
            ST_OVF, ST_BADEND: begin
                if (slot_free) n_state = ST_CHECK;
            end
            ST_FRAME_RD: n_state = ST_FRAME_WR;
            ST_FRAME_WR: begin
                if (slot_free) n_state = rd_last ? ST_CHECK : ST_FRAME_RD;
            end
            ST_CHECK: n_state = timeout_hit ? ST_TMO : ST_IDLE;
            ST_TMO: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_wi         = r_wi;
        n_exp        = r_exp;
        n_deadline   = r_deadline;
        n_armed      = r_armed;
        n_in_timeout = r_in_timeout;
        n_flen       = r_flen;
        n_rd_idx     = r_rd_idx;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        push         = 1'b0;
        push_data    = '{event_kind: EV_FRAME, frame_byte: 8'd0, last_of_frame: 1'b0};
        unique case (r_state)
            ST_DECODE: begin
                unique case (r_item.req_type)
                    REQ_BYTE, REQ_POLL: begin
                        if (r_in_timeout && dl_passed) n_in_timeout = 1'b0;
                    end
                    REQ_RESYNC: begin
                        n_wi         = '0;
                        n_exp        = '0;
                        n_in_timeout = 1'b0;
                    end
                    default: ;
                endcase
            end
            ST_RECOV: begin
                push                 = slot_free;
                push_data.event_kind = EV_RECOVERED;
            end
            ST_REFUSE: begin
                push                 = slot_free;
                push_data.event_kind = EV_REFUSED;
            end
            ST_BYTE: begin
                if (wi_full) begin
                    n_wi  = '0;
                    n_exp = '0;
                end else begin
                    n_exp = exp_new;
                    if (keep) begin
                        n_deadline = dl_sum;
                        mem_we     = 1'b1;
                        if (r_wi == WI_W'(0)) n_armed = 1'b1;
                        if (complete) begin
                            n_wi     = '0;
                            n_armed  = 1'b0;
                            n_flen   = wi_inc;
                            n_rd_idx = '0;
                        end else begin
                            n_wi = wi_inc;
                        end
                    end
                end
            end
            ST_OVF: begin
                push                 = slot_free;
                push_data.event_kind = EV_OVERFLOW;
            end
            ST_BADEND: begin
                push                 = slot_free;
                push_data.event_kind = EV_BAD_END;
            end
            ST_FRAME_RD: mem_re = 1'b1;
            ST_FRAME_WR: begin
                push                    = slot_free;
                push_data.event_kind    = EV_FRAME;
                push_data.frame_byte    = r_rd_data;
                push_data.last_of_frame = rd_last;
                if (slot_free) n_rd_idx = r_rd_idx + ADDR_W'(1);
            end
            ST_CHECK: begin
                if (timeout_hit) begin
                    n_wi         = '0;
                    n_exp        = '0;
                    n_armed      = 1'b0;
                    n_deadline   = dl_sum;
                    n_in_timeout = 1'b1;
                end
            end
            ST_TMO: begin
                push                 = slot_free;
                push_data.event_kind = EV_TIMEOUT;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[r_wi[ADDR_W-1:0]] <= r_item.data_byte;
        if (mem_re) r_rd_data <= mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) r_item <= i_in_data;
        if (push)   r_out  <= push_data;
        r_flen   <= n_flen;
        r_rd_idx <= n_rd_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_timeout_ms <= TIMEOUT_RST;
            r_wi         <= '0;
            r_exp        <= '0;
            r_deadline   <= '0;
            r_armed      <= 1'b0;
            r_in_timeout <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wi         <= n_wi;
            r_exp        <= n_exp;
            r_deadline   <= n_deadline;
            r_armed      <= n_armed;
            r_in_timeout <= n_in_timeout;
            if (i_cfg_we) r_timeout_ms <= i_cfg_wdata;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/sfrt_checker.sv]
`default_nettype none

module sfrt_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_stall,
    input wire                 o_out_valid,
    input wire                 i_out_stall,
    input sfrt_pkg::t_out_item o_out_data
);
    import sfrt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transaction changed");

    a_event_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_kind != EV_FRAME)
        |-> (o_out_data.frame_byte == 8'd0) && !o_out_data.last_of_frame
            && (o_out_data.event_kind <= EV_RECOVERED))
        else $error("event transaction carries frame payload or bad kind");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before previous transaction was worked");

    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

endmodule

bind serial_frame_receiver_with_timeout_unit sfrt_checker u_sfrt_checker (.*);

`default_nettype wire
